/* rtl/core/bch_pkg.sv */
package bch_pkg;

    // code geometry
    localparam int CODE_N      = 31;
    localparam int CODE_K      = 16;
    localparam int PARITY_BITS = CODE_N - CODE_K;

    // generator register
    localparam int              GEN_W     = 16;
    localparam logic [GEN_W-1:0] GEN_RESET = 16'h8FAF;

    // frame constants
    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] HEADER_BYTE = 8'h80;

    // front sequencer: one message byte per step through the parity LFSR
    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_HIGH,
        FRONT_LOW,
        FRONT_PUSH
    } t_front_state;

    // back serializer: which frame byte goes out next
    typedef enum logic [2:0] {
        SLOT_SYNC,
        SLOT_HEADER,
        SLOT_B3,
        SLOT_B2,
        SLOT_B1,
        SLOT_B0
    } t_slot;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/core/bch_31_16_encode_framer.sv */
// BCH(31,16) encoder and framer: one message in, six frame bytes out.
// The front LFSR takes the high, then the low message byte, 8 bits per cycle;
// the codeword is queued, popped into the serializer's word register, and each
// frame byte is registered at the output. Throughput is set by the byte-wide
// output serializer; new messages are taken while earlier ones go out.
// Reset: synchronous, active low; clears queue and sequencers, generator = 0x8FAF.
module bch_31_16_encode_framer import bch_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GEN_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_msg_high,
    input  logic [7:0]        i_msg_low,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_frame_byte,
    output logic              o_frame_last
);

    logic [GEN_W-1:0]   r_gen;
    logic               push, pop;
    logic [CODE_N-1:0]  push_data, pop_data;
    t_q_stat            q_stat;

    // generator polynomial register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= GEN_RESET;
        end else if (i_cfg_we) begin
            r_gen <= i_cfg_wdata;
        end
    end

    // front: accept and compute parity
    bch_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gen       (r_gen),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_msg_high  (i_msg_high),
        .i_msg_low   (i_msg_low),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // codeword queue
    bch_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    // back: frame serializer
    bch_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_q_data     (pop_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

endmodule

/* rtl/core/bch_front.sv */
module bch_front import bch_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [GEN_W-1:0]       i_gen,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_msg_high,
    input  logic [7:0]             i_msg_low,
    input  t_q_stat                i_q_stat,
    output logic                   o_push,
    output logic [CODE_N-1:0]      o_push_data
);

    // eight LFSR shifts of the division by g (x^15 term implied)
    function automatic logic [PARITY_BITS-1:0] lfsr_byte(
        input logic [PARITY_BITS-1:0] rem,
        input logic [7:0]             data,
        input logic [PARITY_BITS-1:0] g
    );
        logic [PARITY_BITS-1:0] r;
        logic                   fb;
        r = rem;
        for (int k = 7; k >= 0; k--) begin
            fb = data[k] ^ r[PARITY_BITS-1];
            r  = {r[PARITY_BITS-2:0], 1'b0} ^ (fb ? g : '0);
        end
        return r;
    endfunction

    t_front_state             r_state, n_state;
    logic [CODE_K-1:0]        r_msg, n_msg;
    logic [PARITY_BITS-1:0]   r_rem, n_rem;
    logic                     accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRONT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
        r_rem <= n_rem;
    end

    // ready when idle, or when the finished word leaves this cycle
    assign o_in_stall = !((r_state == FRONT_IDLE) ||
                          (r_state == FRONT_PUSH && !i_q_stat.full));
    assign accept     = i_in_valid && !o_in_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_msg   = r_msg;
        n_rem   = r_rem;
        o_push  = 1'b0;
        unique case (r_state)
            FRONT_IDLE: begin
                if (accept) begin
                    n_state = FRONT_HIGH;
                end
            end
            FRONT_HIGH: begin
                n_rem   = lfsr_byte(r_rem, r_msg[15:8], i_gen[PARITY_BITS-1:0]);
                n_state = FRONT_LOW;
            end
            FRONT_LOW: begin
                n_rem   = lfsr_byte(r_rem, r_msg[7:0], i_gen[PARITY_BITS-1:0]);
                n_state = FRONT_PUSH;
            end
            FRONT_PUSH: begin
                if (!i_q_stat.full) begin
                    o_push  = 1'b1;
                    n_state = accept ? FRONT_HIGH : FRONT_IDLE;
                end
            end
            default: begin
                n_state = FRONT_IDLE;
            end
        endcase
        // new message starts with a clear remainder
        if (accept) begin
            n_msg = {i_msg_high, i_msg_low};
            n_rem = '0;
        end
    end

    // codeword: message over parity
    assign o_push_data = {r_msg, r_rem};

endmodule

/* rtl/core/bch_queue.sv */
module bch_queue import bch_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [CODE_N-1:0]   i_push_data,
    input  logic                i_pop,
    output logic [CODE_N-1:0]   o_pop_data,
    output t_q_stat             o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CODE_N-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_push_data;
    end

    assign o_pop_data = r_mem[r_rd_ptr];

endmodule

/* rtl/core/bch_back.sv */
module bch_back import bch_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_q_stat             i_q_stat,
    input  logic [CODE_N-1:0]   i_q_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_frame_byte,
    output logic                o_frame_last
);

    t_slot               r_slot, n_slot;
    logic                r_active, n_active;
    logic                r_valid, n_valid;
    logic [CODE_N-1:0]   r_word, n_word;
    logic [7:0]          r_byte, n_byte;
    logic                r_last, n_last;
    logic [31:0]         word32;
    logic                adv, emit_last;
    logic [7:0]          sel_byte;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= SLOT_SYNC;
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_slot   <= n_slot;
            r_active <= n_active;
            r_valid  <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    // frame byte for the current slot
    assign word32 = {1'b0, r_word};
    always_comb begin
        unique case (r_slot)
            SLOT_SYNC:   sel_byte = SYNC_BYTE;
            SLOT_HEADER: sel_byte = HEADER_BYTE;
            SLOT_B3:     sel_byte = word32[31:24];
            SLOT_B2:     sel_byte = word32[23:16];
            SLOT_B1:     sel_byte = word32[15:8];
            SLOT_B0:     sel_byte = word32[7:0];
            default:     sel_byte = SYNC_BYTE;
        endcase
    end

    // output register moves when empty or taken
    assign adv       = !r_valid || !i_out_stall;
    assign emit_last = r_active && (r_slot == SLOT_B0);
    assign o_pop     = !i_q_stat.empty && (!r_active || (adv && emit_last));

    // serializer
    always_comb begin
        n_slot   = r_slot;
        n_active = r_active;
        n_valid  = r_valid;
        n_word   = r_word;
        n_byte   = r_byte;
        n_last   = r_last;
        if (adv) begin
            n_valid = r_active;
            n_byte  = sel_byte;
            n_last  = emit_last;
            if (r_active) begin
                if (emit_last) begin
                    n_active = 1'b0;
                    n_slot   = SLOT_SYNC;
                end else begin
                    n_slot = t_slot'(r_slot + 3'd1);
                end
            end
        end
        // next word loads when idle or behind the last byte
        if (o_pop) begin
            n_word   = i_q_data;
            n_active = 1'b1;
            n_slot   = SLOT_SYNC;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_last = r_last;

endmodule
